// File: rtl/stereo_point_triangulation_macros.svh
// assertion macros shared by the stereo triangulation checker
`ifndef STEREO_POINT_TRIANGULATION_MACROS_SVH
`define STEREO_POINT_TRIANGULATION_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/spt_pkg.sv
// shared widths, register indexes and defaults of the stereo triangulation block
package spt_pkg;

  localparam int unsigned CoordWidthDefault = 32;

  localparam int unsigned PixWidth   = 16;
  localparam int unsigned FocalWidth = 20;
  localparam int unsigned BaseWidth  = 16;
  localparam int unsigned CfgWidth   = 20;
  localparam int unsigned CfgIdxWidth = 2;

  // product, rounded dividend, divisor and quotient widths
  localparam int unsigned ProdWidth = FocalWidth + BaseWidth;
  localparam int unsigned NW = ProdWidth + 5;
  localparam int unsigned DW = PixWidth + 8;
  localparam int unsigned QW = 33;

  localparam logic [CfgIdxWidth-1:0] RegFocal   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegBase    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegCenterX = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegCenterY = 2'd3;

  localparam logic [FocalWidth-1:0] FocalReset   = 20'd16384;
  localparam logic [BaseWidth-1:0]  BaseReset    = 16'd15360;
  localparam logic [PixWidth-1:0]   CenterXReset = 16'd10240;
  localparam logic [PixWidth-1:0]   CenterYReset = 16'd7680;

endpackage

// File: rtl/spt_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module spt_div_pipe (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [spt_pkg::NW-1:0] num_i,
  input  logic [spt_pkg::DW-1:0] den_i,
  input  logic                  neg_i,
  output logic [spt_pkg::QW-1:0] quot_o,
  output logic                  neg_o
);
  import spt_pkg::*;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] lo_q  [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic          neg_q [QW+1];

  // load: high dividend bits seed the remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(num_i[NW-1:QW]);
      lo_q[0]  <= num_i[QW-1:0];
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_d;

    assign trial = {rem_q[s], lo_q[s][QW-1]};
    assign diff  = trial - {1'b0, den_q[s]};
    assign ge    = trial >= {1'b0, den_q[s]};
    assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d;
        lo_q[s+1]  <= {lo_q[s][QW-2:0], ge};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quot_o = lo_q[QW];
  assign neg_o  = neg_q[QW];

endmodule

// File: rtl/stereo_point_triangulation.sv
// top level of the stereo point triangulation pipeline
// Triangulates one matched point pair of a rectified stereo rig per cycle. Disparity d is
// left_x minus right_x; Z = focal*baseline/d, X = (left_x-cx)*baseline/d and
// Y = (left_y-cy)*baseline/d, each rounded to the nearest 1/16 mm (halves away from zero)
// and clamped to the signed CoordWidth range, with saturated flagging any clamp. Zero
// disparity gives valid_res low and all coordinates zero. Throughput is one item per
// cycle; the three restoring dividers retire one quotient bit per stage. The whole
// pipeline advances together whenever the output register is empty or being taken,
// so a stall holds every stage in place.
module stereo_point_triangulation #(
  parameter int unsigned CoordWidth = spt_pkg::CoordWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [spt_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [spt_pkg::CfgWidth-1:0]    cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [spt_pkg::PixWidth-1:0]    left_x_i,
  input  logic [spt_pkg::PixWidth-1:0]    left_y_i,
  input  logic [spt_pkg::PixWidth-1:0]    right_x_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           valid_res_o,
  output logic                           saturated_o,
  output logic signed [CoordWidth-1:0]   x_mm_o,
  output logic signed [CoordWidth-1:0]   y_mm_o,
  output logic signed [CoordWidth-1:0]   z_mm_o
);
  import spt_pkg::*;

  localparam int unsigned EW = QW + CoordWidth;
  localparam logic [EW-1:0] PosMax = (EW'(1) << (CoordWidth - 1)) - EW'(1);
  localparam logic [EW-1:0] NegMax = EW'(1) << (CoordWidth - 1);

  // configuration registers
  logic [FocalWidth-1:0] focal_q;
  logic [BaseWidth-1:0]  base_q;
  logic [PixWidth-1:0]   cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= FocalReset;
      base_q  <= BaseReset;
      cx_q    <= CenterXReset;
      cy_q    <= CenterYReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFocal:   focal_q <= cfg_data_i;
        RegBase:    base_q  <= cfg_data_i[BaseWidth-1:0];
        RegCenterX: cx_q    <= cfg_data_i[PixWidth-1:0];
        RegCenterY: cy_q    <= cfg_data_i[PixWidth-1:0];
        default: ;
      endcase
    end
  end

  // global advance: output empty or being taken
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: disparity, center offsets and the three products
  logic                 dneg, oxneg, oyneg;
  logic [PixWidth-1:0]  dmag, oxmag, oymag;

  assign dneg  = left_x_i < right_x_i;
  assign dmag  = dneg ? right_x_i - left_x_i : left_x_i - right_x_i;
  assign oxneg = left_x_i < cx_q;
  assign oxmag = oxneg ? cx_q - left_x_i : left_x_i - cx_q;
  assign oyneg = left_y_i < cy_q;
  assign oymag = oyneg ? cy_q - left_y_i : left_y_i - cy_q;

  logic                 v1_q, v2_q;
  logic                 zero1_q, zero2_q;
  logic [PixWidth-1:0]  dmag1_q;
  logic                 zneg1_q, xneg1_q, yneg1_q;
  logic                 zneg2_q, xneg2_q, yneg2_q;
  logic [ProdWidth-1:0] pz1_q, px1_q, py1_q;
  logic [NW-1:0]        nz2_q, nx2_q, ny2_q;
  logic [DW-1:0]        den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero1_q <= dmag == '0;
      dmag1_q <= dmag;
      zneg1_q <= dneg;
      xneg1_q <= oxneg ^ dneg;
      yneg1_q <= oyneg ^ dneg;
      pz1_q   <= focal_q * base_q;
      px1_q   <= ProdWidth'(oxmag * base_q);
      py1_q   <= ProdWidth'(oymag * base_q);
    end
  end

  // stage 2: dividend scaled to 1/16 mm plus half the divisor for rounding
  logic [NW-1:0] half_den;
  assign half_den = NW'(dmag1_q) << 7;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero2_q <= zero1_q;
      zneg2_q <= zneg1_q;
      xneg2_q <= xneg1_q;
      yneg2_q <= yneg1_q;
      den2_q  <= DW'(dmag1_q) << 8;
      nz2_q   <= (NW'(pz1_q) << 4) + half_den;
      nx2_q   <= (NW'(px1_q) << 4) + half_den;
      ny2_q   <= (NW'(py1_q) << 4) + half_den;
    end
  end

  // divider lanes: z, x, y
  logic [NW-1:0] lane_num [3];
  logic          lane_neg [3];
  logic [QW-1:0] lane_quot [3];
  logic          lane_qneg [3];

  assign lane_num[0] = nz2_q;
  assign lane_num[1] = nx2_q;
  assign lane_num[2] = ny2_q;
  assign lane_neg[0] = zneg2_q;
  assign lane_neg[1] = xneg2_q;
  assign lane_neg[2] = yneg2_q;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    spt_div_pipe u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (lane_num[l]),
      .den_i  (den2_q),
      .neg_i  (lane_neg[l]),
      .quot_o (lane_quot[l]),
      .neg_o  (lane_qneg[l])
    );
  end

  // valid and zero-disparity flags travel alongside the divider stages
  logic vld_q  [QW+1];
  logic zero_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QW; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v2_q;
      for (int i = 1; i <= QW; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q[0] <= zero2_q;
      for (int i = 1; i <= QW; i++) zero_q[i] <= zero_q[i-1];
    end
  end

  // clamp and sign each lane
  logic [CoordWidth-1:0] coord [3];
  logic [2:0]            lane_sat;

  for (genvar l = 0; l < 3; l++) begin : g_clamp
    logic [EW-1:0] ext, lim, mag;
    assign ext         = EW'(lane_quot[l]);
    assign lim         = lane_qneg[l] ? NegMax : PosMax;
    assign lane_sat[l] = ext > lim;
    assign mag         = lane_sat[l] ? lim : ext;
    assign coord[l]    = lane_qneg[l] ? CoordWidth'(EW'(0) - mag) : mag[CoordWidth-1:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero_q[QW]) begin
        valid_res_o <= 1'b0;
        saturated_o <= 1'b0;
        z_mm_o      <= '0;
        x_mm_o      <= '0;
        y_mm_o      <= '0;
      end else begin
        valid_res_o <= 1'b1;
        saturated_o <= |lane_sat;
        z_mm_o      <= coord[0];
        x_mm_o      <= coord[1];
        y_mm_o      <= coord[2];
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/spt_checker.sv
// port-level checks of the stereo triangulation block and their bind
`include "stereo_point_triangulation_macros.svh"

module spt_checker #(
  parameter int unsigned CoordWidth = spt_pkg::CoordWidthDefault
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         valid_res_o,
  input logic                         saturated_o,
  input logic signed [CoordWidth-1:0] x_mm_o,
  input logic signed [CoordWidth-1:0] y_mm_o,
  input logic signed [CoordWidth-1:0] z_mm_o
);

  // a stalled result stays offered
  `SPT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // a stalled result keeps its depth
  `SPT_ASSERT_NEXT(a_z_stable, out_valid_o && !out_ready_i, $stable(z_mm_o), "z changed")

  // skipped points carry all-zero coordinates
  `SPT_ASSERT_NOW(a_skip_zero, out_valid_o && !valid_res_o,
                  !saturated_o && x_mm_o == '0 && y_mm_o == '0 && z_mm_o == '0,
                  "skipped item not zero")

  // clamping only happens on computed points
  `SPT_ASSERT_NOW(a_sat_valid, out_valid_o && saturated_o, valid_res_o,
                  "saturated without valid result")

endmodule

bind stereo_point_triangulation spt_checker #(.CoordWidth(CoordWidth)) u_spt_checker (.*);
